FILE: src/tubc_pkg.sv
// Shared types and constants for the texture unit binding cache.
// No dependencies; every other file of the block but tubc_ram imports this package.
package tubc_pkg;

  localparam int NUM_UNITS_DEF = 32;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int UNIT_INDEX_W  = 5;
  localparam int MAX_UNITS_W   = 6;

  localparam logic [MAX_UNITS_W-1:0] MAX_UNITS_RST = MAX_UNITS_W'(32);

  localparam logic REQ_BIND  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic flush;
  } tubc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } tubc_status_t;

endpackage

FILE: src/tubc_req_if.sv
// Request channel: valid/ready handshake with request type and texture key.
// Depends on tubc_pkg.
interface tubc_req_if
  import tubc_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [KEY_WIDTH-1:0] texture_key;

  modport source (output valid, output req_type, output texture_key, input ready);
  modport sink   (input valid, input req_type, input texture_key, output ready);
endinterface

FILE: src/tubc_rsp_if.sv
// Response channel: valid/ready handshake with the unit assignment result.
// Depends on tubc_pkg.
interface tubc_rsp_if
  import tubc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [UNIT_INDEX_W-1:0] unit_index;
  logic                    was_hit;
  logic                    do_bind;
  logic                    unbind_all;

  modport source (output valid, output unit_index, output was_hit, output do_bind,
                  output unbind_all, input ready);
  modport sink   (input valid, input unit_index, input was_hit, input do_bind,
                  input unbind_all, output ready);
endinterface

FILE: src/tubc_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the unit limit.
// Depends on tubc_pkg.
interface tubc_cfg_if
  import tubc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [MAX_UNITS_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tubc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tubc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/tubc_ctrl.sv
// Request sequencer: accepts a request, drives the key scan and commits the result, or the
// flush, once the response register is free. Depends on tubc_pkg.
module tubc_ctrl
  import tubc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  tubc_status_t status,
  output tubc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = (req_type == REQ_FLUSH) ? FLUSH : SCAN;
        end
      end
      SCAN: begin
        if (!status.scan_done) begin
          cmd.scan = 1'b1;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/tubc_dp.sv
// Datapath: key store, scan pointer, allocation count, recency pointer,
// unit limit and response register. Depends on tubc_pkg and tubc_ram.
module tubc_dp
  import tubc_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tubc_cmd_t               cmd,
  output tubc_status_t            status,
  input  logic [KEY_WIDTH-1:0]    texture_key,
  input  logic                    cfg_valid,
  input  logic [MAX_UNITS_W-1:0]  cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [UNIT_INDEX_W-1:0] unit_index,
  output logic                    was_hit,
  output logic                    do_bind,
  output logic                    unbind_all
);

  localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int CNT_W = $clog2(NUM_UNITS + 1);
  localparam int CMP_W = (CNT_W > MAX_UNITS_W) ? CNT_W : MAX_UNITS_W;

  logic [KEY_WIDTH-1:0]   key;
  logic [CNT_W-1:0]       scan_idx;
  logic                   pend;
  logic [IDX_W-1:0]       pend_idx;
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  logic [CNT_W-1:0]       units_allocated;
  logic [IDX_W-1:0]       recent_unit;
  logic [MAX_UNITS_W-1:0] max_units;

  logic                   scan_more;
  logic [KEY_WIDTH-1:0]   rd_data;
  logic                   match;
  logic [CMP_W-1:0]       alloc_ext;
  logic [CMP_W-1:0]       limit;
  logic                   full;
  logic [IDX_W-1:0]       unit_sel;
  logic                   wr_en;
  logic [IDX_W+UNIT_INDEX_W-1:0] unit_ext;

  assign scan_more = scan_idx < units_allocated;
  assign match     = pend && (rd_data == key);

  assign alloc_ext = CMP_W'(units_allocated);
  assign limit     = (max_units == '0) ? CMP_W'(1) : CMP_W'(max_units);
  assign full      = (alloc_ext >= limit) || (alloc_ext >= CMP_W'(NUM_UNITS));

  always_comb begin
    if (found) begin
      unit_sel = found_idx;
    end else if (!full) begin
      unit_sel = units_allocated[IDX_W-1:0];
    end else begin
      unit_sel = recent_unit;
    end
  end

  assign wr_en    = cmd.commit && !found;
  assign unit_ext = {{UNIT_INDEX_W{1'b0}}, unit_sel};

  assign status.scan_done = found || (!pend && !scan_more);
  assign status.out_free  = !out_valid || out_ready;

  tubc_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(NUM_UNITS)
  ) u_keys (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(unit_sel),
    .wr_data(key),
    .rd_en  (cmd.scan && scan_more),
    .rd_addr(scan_idx[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= texture_key;
    end
    if (cmd.scan) begin
      pend_idx <= scan_idx[IDX_W-1:0];
      if (match) begin
        found_idx <= pend_idx;
      end
    end
    if (cmd.commit) begin
      unit_index <= unit_ext[UNIT_INDEX_W-1:0];
      was_hit    <= found;
      do_bind    <= !found;
      unbind_all <= 1'b0;
    end else if (cmd.flush) begin
      unit_index <= '0;
      was_hit    <= 1'b0;
      do_bind    <= 1'b0;
      unbind_all <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx        <= '0;
      pend            <= 1'b0;
      found           <= 1'b0;
      units_allocated <= '0;
      recent_unit     <= '0;
      max_units       <= MAX_UNITS_RST;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_units <= cfg_data;
      end
      if (cmd.start) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.scan) begin
        pend <= scan_more;
        if (scan_more) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (match) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (found) begin
          recent_unit <= found_idx;
        end else if (!full) begin
          recent_unit     <= unit_sel;
          units_allocated <= units_allocated + CNT_W'(1);
        end
      end else if (cmd.flush) begin
        units_allocated <= '0;
        recent_unit     <= '0;
      end
      if (cmd.commit || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/texture_unit_binding_cache.sv
// Texture unit binding cache: maps texture keys onto a limited set of units.
// A bind request scans the allocated keys one per cycle; a flush responds without a scan.
// A held response stalls the commit; the block returns to idle as the response is registered.
// Reset clears the allocation count and recency pointer and sets the limit to 32; the key
// store is not initialised. Uses tubc_ctrl, tubc_dp.
module texture_unit_binding_cache
  import tubc_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tubc_req_if.sink   req,
  tubc_rsp_if.source rsp,
  tubc_cfg_if.sink   cfg
);

  tubc_cmd_t    cmd;
  tubc_status_t status;

  assign cfg.ready = 1'b1;

  tubc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .req_type(req.req_type),
    .status  (status),
    .cmd     (cmd)
  );

  tubc_dp #(
    .NUM_UNITS(NUM_UNITS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .texture_key(req.texture_key),
    .cfg_valid  (cfg.valid),
    .cfg_data   (cfg.data),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .unit_index (rsp.unit_index),
    .was_hit    (rsp.was_hit),
    .do_bind    (rsp.do_bind),
    .unbind_all (rsp.unbind_all)
  );

endmodule

FILE: tb/texture_unit_binding_cache_tb.sv
// Testbench for texture_unit_binding_cache: a directed table and then random phases under
// changing unit limits, each response checked against the table's expected value or a behavioural model of the cache.
// Depends on tubc_pkg, the request, response and configuration interfaces, and the block.
module texture_unit_binding_cache_tb;
  import tubc_pkg::*;

  typedef struct packed {
    logic [UNIT_INDEX_W-1:0] unit_index;
    logic                    was_hit;
    logic                    do_bind;
    logic                    unbind_all;
  } binding_t;

  typedef struct packed {
    bit        is_cfg;
    logic      req_type;
    logic [31:0] value;
    bit        typed;
    binding_t  want;
  } plan_row_t;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int PHASE_ITEMS     = 68;

  localparam plan_row_t DIRECTED [0:23] = '{
    '{1'b1, REQ_BIND,  32'd2,        1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000000, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_BIND,  32'hFFFFFFFF, 1'b1, '{5'd1, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_BIND,  32'h00000000, 1'b1, '{5'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REQ_BIND,  32'h12345678, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_BIND,  32'h00000000, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_BIND,  32'hFFFFFFFF, 1'b1, '{5'd1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REQ_BIND,  32'hA5A5A5A5, 1'b1, '{5'd1, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_FLUSH, 32'h00000000, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, REQ_FLUSH, 32'hFFFFFFFF, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, REQ_BIND,  32'hA5A5A5A5, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b1, REQ_BIND,  32'd0,        1'b0, '0},
    '{1'b0, REQ_BIND,  32'h5A5A5A5A, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, REQ_BIND,  32'h5A5A5A5A, 1'b1, '{5'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b1, REQ_BIND,  32'd63,       1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000001, 1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000002, 1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000003, 1'b0, '0},
    '{1'b1, REQ_BIND,  32'd1,        1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000002, 1'b0, '0},
    '{1'b0, REQ_BIND,  32'h00000009, 1'b0, '0},
    '{1'b0, REQ_BIND,  32'h5A5A5A5A, 1'b0, '0},
    '{1'b0, REQ_FLUSH, 32'h00000000, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, REQ_BIND,  32'hFFFFFFFF, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0}}
  };

  localparam logic [MAX_UNITS_W-1:0] CAP_PLAN [0:9] = '{
    6'd32, 6'd1, 6'd4, 6'd0, 6'd63, 6'd17, 6'd8, 6'd33, 6'd2, 6'd31
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tubc_req_if #(.KEY_WIDTH(KEY_WIDTH_DEF)) req_ch ();
  tubc_rsp_if rsp_ch ();
  tubc_cfg_if cfg_ch ();

  texture_unit_binding_cache #(
    .NUM_UNITS(NUM_UNITS_DEF),
    .KEY_WIDTH(KEY_WIDTH_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0]             held_keys [NUM_UNITS_DEF];
  int                      units_in_use = 0;
  logic [UNIT_INDEX_W-1:0] mru_unit = '0;
  logic [MAX_UNITS_W-1:0]  unit_cap = MAX_UNITS_RST;

  binding_t pending_bindings [$];
  int       errors = 0;
  int       send_calm = 0;
  int       recv_calm = 0;
  int       quiet_cycles = 0;

  function automatic int cap_in_use();
    if (unit_cap == 0) return 1;
    if (unit_cap > NUM_UNITS_DEF) return NUM_UNITS_DEF;
    return int'(unit_cap);
  endfunction

  function automatic binding_t resolve_binding(logic rt, logic [31:0] key);
    binding_t res;
    bit       found;
    res = '0;
    found = 1'b0;
    if (rt == REQ_FLUSH) begin
      units_in_use = 0;
      mru_unit = '0;
      res.unbind_all = 1'b1;
      return res;
    end
    for (int i = 0; i < units_in_use; i++) begin
      if (!found && held_keys[i] == key) begin
        found = 1'b1;
        res.unit_index = UNIT_INDEX_W'(i);
      end
    end
    if (found) begin
      res.was_hit = 1'b1;
      mru_unit = res.unit_index;
    end else if (units_in_use < cap_in_use()) begin
      res.unit_index = UNIT_INDEX_W'(units_in_use);
      held_keys[units_in_use] = key;
      units_in_use++;
      mru_unit = res.unit_index;
      res.do_bind = 1'b1;
    end else begin
      res.unit_index = mru_unit;
      held_keys[mru_unit] = key;
      res.do_bind = 1'b1;
    end
    return res;
  endfunction

  task automatic send_request(input logic rt, input logic [31:0] key, input bit typed,
                              input binding_t want);
    int unsigned pause;
    binding_t    predicted;
    if (send_calm > 0) begin
      send_calm--;
      pause = 0;
    end else begin
      pause = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(5, 30);
    end
    @(negedge clk);
    if (pause != 0) begin
      req_ch.valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rt;
    req_ch.texture_key <= key;
    do @(posedge clk); while (!req_ch.ready);
    predicted = resolve_binding(rt, key);
    pending_bindings.push_back(typed ? want : predicted);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_bindings.size() != 0) @(negedge clk);
  endtask

  task automatic write_unit_cap(input logic [MAX_UNITS_W-1:0] cap);
    drain_requests();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    unit_cap = cap;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
      $display("texture_unit_binding_cache verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    binding_t    seen;
    binding_t    want;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (recv_calm > 0) begin
        recv_calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(5, 30);
      end
      @(negedge clk);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      seen = '{rsp_ch.unit_index, rsp_ch.was_hit, rsp_ch.do_bind, rsp_ch.unbind_all};
      if (pending_bindings.size() == 0) begin
        $display("%0t: unexpected response expected none got unit=%0d hit=%0b bind=%0b unbind=%0b",
                 $time, seen.unit_index, seen.was_hit, seen.do_bind, seen.unbind_all);
        errors++;
      end else begin
        want = pending_bindings.pop_front();
        if (seen !== want) begin
          $display("%0t: response mismatch expected unit=%0d hit=%0b bind=%0b unbind=%0b",
                   $time, want.unit_index, want.was_hit, want.do_bind, want.unbind_all);
          $display("%0t:                   got      unit=%0d hit=%0b bind=%0b unbind=%0b",
                   $time, seen.unit_index, seen.was_hit, seen.do_bind, seen.unbind_all);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] key_pool [48];
    int          pool_size;
    int          lim;
    int unsigned pick;
    binding_t    left;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_BIND;
    req_ch.texture_key = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg)
        write_unit_cap(DIRECTED[r].value[MAX_UNITS_W-1:0]);
      else
        send_request(DIRECTED[r].req_type, DIRECTED[r].value, DIRECTED[r].typed,
                     DIRECTED[r].want);
    end

    // keep a pool a little larger than the limit so hits and evictions both occur
    foreach (CAP_PLAN[p]) begin
      write_unit_cap(CAP_PLAN[p]);
      lim = cap_in_use();
      pool_size = lim + lim / 4 + 2;
      for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      if ($urandom_range(0, 1)) key_pool[0] = 32'h00000000;
      if ($urandom_range(0, 1)) key_pool[pool_size-1] = 32'hFFFFFFFF;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)
          send_request(REQ_FLUSH, $urandom, 1'b0, '0);
        else if (pick < 88)
          send_request(REQ_BIND, key_pool[$urandom_range(0, pool_size - 1)], 1'b0, '0);
        else
          send_request(REQ_BIND, $urandom, 1'b0, '0);
      end
    end

    drain_requests();
    repeat (40) @(posedge clk);
    while (pending_bindings.size() != 0) begin
      left = pending_bindings.pop_front();
      $display("%0t: missing response expected unit=%0d hit=%0b bind=%0b unbind=%0b got none",
               $time, left.unit_index, left.was_hit, left.do_bind, left.unbind_all);
      errors++;
    end
    if (errors == 0)
      $display("texture_unit_binding_cache verification clean");
    else
      $display("texture_unit_binding_cache verification failed");
    $finish;
  end

endmodule
